/* design/text_console_writer_assert.svh */
// Assertion macros used by tcw_ctrl of the text console writer RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TCW_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define TCW_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

/* design/tcw_pkg.sv */
// Shared constants, command codes and beat layouts for the text console writer.
// No dependencies; imported by text_console_writer and tcw_ctrl.
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths.
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 4;

  // Derived widths for the buffer address, sweep counter, column and row.
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SWEEP_W = $clog2(CELLS + 1);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  localparam logic [POS_W-1:0]  LAST_CELL  = POS_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);

  // Reciprocal of COLUMNS for splitting a cell index into row and column.
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / COLUMNS;
  localparam int PROD_W   = POS_W + RECIP_SH;

  // Cell masks.
  localparam logic [CELL_W-1:0] CHAR_KEEP_MASK = 16'hFF00;
  localparam logic [CELL_W-1:0] ATTR_KEEP_MASK = 16'h00FF;
  localparam logic [CELL_W-1:0] FG_KEEP_MASK   = 16'hF0FF;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK    = 8'h0F;

  // Control characters understood when printing.
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;

  // Command codes carried in tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_PRINT      = 4'd0,
    MODE_WRITE_CHAR = 4'd1,
    MODE_WRITE_ATTR = 4'd2,
    MODE_WRITE_CELL = 4'd3,
    MODE_READ       = 4'd4,
    MODE_SET_FG     = 4'd5,
    MODE_CURSOR     = 4'd6,
    MODE_FILL       = 4'd7,
    MODE_SCROLL     = 4'd8
  } mode_t;

  // Input tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic [4:0]        pad;
    logic [CELL_W-1:0] cell_word;
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] char_code;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  // Output tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic [4:0]        pad;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] read_cell;
  } out_beat_t;

  localparam int IN_TDATA_W  = $bits(in_beat_t);
  localparam int OUT_TDATA_W = $bits(out_beat_t);

  // Port of the screen buffer as driven by the controller.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
  } ram_req_t;

endpackage

/* design/text_console_writer.sv */
// Text console writer: 80x25 screen of 16-bit cells in one RAM. A print, positional or
// cursor command is latched from its input beat, executes after its cell is read and
// loads its result into the output register; fill and scroll sweep every cell through
// the RAM port. One command is in work at a time; the output register frees the next
// input beat. After rst a clearing pass zeroes the buffer, one cell a cycle, with
// s_axis_tready low; the cursor resets to zero.
module text_console_writer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // position[10:0], char_code[18:11], attr[26:19], cell_word[42:27], zero pad
  input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[3:0]
  input  logic [tcw_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_cell[15:0], cursor_position[26:16], zero pad
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import tcw_pkg::*;

  in_beat_t          in_beat;
  out_beat_t         out_beat;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rd_data;
  logic              out_free;
  logic              res_valid;
  logic [CELL_W-1:0] res_cell;
  logic [POS_W-1:0]  res_cursor;

  assign in_beat = in_beat_t'(s_axis_tdata);

  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (s_axis_tvalid),
    .cmd_ready    (s_axis_tready),
    .cmd_mode     (mode_t'(s_axis_tuser)),
    .cmd_position (in_beat.position),
    .cmd_char     (in_beat.char_code),
    .cmd_attr     (in_beat.attr),
    .cmd_word     (in_beat.cell_word),
    .ram_req      (ram_req),
    .ram_rd_data  (ram_rd_data),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res_cell     (res_cell),
    .res_cursor   (res_cursor)
  );

  tcw_ram #(
    .DEPTH  (CELLS),
    .WIDTH  (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_screen (
    .clk     (clk),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data)
  );

  // Output register: free when empty or when its beat leaves this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_beat.pad             <= '0;
      out_beat.read_cell       <= res_cell;
      out_beat.cursor_position <= res_cursor;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_beat);

endmodule

/* design/tcw_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; used for the screen buffer of the text console writer.
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/tcw_ctrl.sv */
// Command sequencer of the text console writer: cursor, read-modify-write and sweeps.
// Depends on tcw_pkg and text_console_writer_assert.svh; drives the tcw_ram port.
`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  tcw_pkg::mode_t           cmd_mode,
  input  logic [tcw_pkg::POS_W-1:0]  cmd_position,
  input  logic [tcw_pkg::BYTE_W-1:0] cmd_char,
  input  logic [tcw_pkg::BYTE_W-1:0] cmd_attr,
  input  logic [tcw_pkg::CELL_W-1:0] cmd_word,
  output tcw_pkg::ram_req_t        ram_req,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rd_data,
  input  logic                     out_free,
  output logic                     res_valid,
  output logic [tcw_pkg::CELL_W-1:0] res_cell,
  output logic [tcw_pkg::POS_W-1:0]  res_cursor
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_SWEEP, ST_DONE} state_t;

  state_t               state;
  logic [POS_W-1:0]     cursor;
  logic [COL_W-1:0]     col;
  logic [SWEEP_W-1:0]   sweep_idx;
  logic                 wr_pend;
  logic [ADDR_W-1:0]    wr_idx;
  mode_t                item_mode;
  logic [BYTE_W-1:0]    item_char;
  logic [BYTE_W-1:0]    item_attr;
  logic [CELL_W-1:0]    item_word;
  logic                 item_in_range;
  logic [ADDR_W-1:0]    item_addr;
  logic [POS_W-1:0]     item_pos;
  logic [ROW_W-1:0]     quot;
  logic [CELL_W-1:0]    res_cell_r;

  logic                 accept;
  logic                 in_range_in;
  logic [POS_W-1:0]     pos_clamped;
  logic [POS_W-1:0]     cursor_dec;
  logic [ADDR_W-1:0]    idle_addr;
  logic [PROD_W-1:0]    quot_prod;
  logic                 sweep_live;
  logic [ADDR_W-1:0]    sweep_src;
  logic [CELL_W-1:0]    sweep_data;
  logic [POS_W-1:0]     rem_raw;
  logic [COL_W:0]       rem_w;
  logic [COL_W-1:0]     rem_col;
  logic [POS_W:0]       nl_sum;
  logic [POS_W-1:0]     cursor_next;
  logic [COL_W-1:0]     col_next;
  logic                 exec_we;
  logic [CELL_W-1:0]    exec_data;
  logic [CELL_W-1:0]    cell_out;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // Decode of the incoming beat: range check, clamp and read address.
  assign in_range_in = (cmd_position <= LAST_CELL);
  assign pos_clamped = in_range_in ? cmd_position : LAST_CELL;
  assign cursor_dec  = cursor - POS_W'(1);
  always_comb begin
    if (cmd_mode == MODE_PRINT) begin
      idle_addr = (cmd_char == CH_BACKSPACE) ? cursor_dec[ADDR_W-1:0] : cursor[ADDR_W-1:0];
    end else begin
      idle_addr = cmd_position[ADDR_W-1:0];
    end
  end

  // Row estimate of a new cursor by reciprocal multiplication; may be one low.
  assign quot_prod = PROD_W'(pos_clamped) * PROD_W'(RECIP);

  // Column of the new cursor, corrected for a low row estimate.
  assign rem_raw = item_pos - (POS_W'(quot) * POS_W'(COLUMNS));
  assign rem_w   = rem_raw[COL_W:0];
  assign rem_col = (rem_w >= (COL_W + 1)'(COLUMNS)) ? COL_W'(rem_w - (COL_W + 1)'(COLUMNS))
                                                    : rem_w[COL_W-1:0];

  // Start of the next row for a newline, before clamping.
  assign nl_sum = (POS_W + 1)'(cursor) + (POS_W + 1)'(COLUMNS) - (POS_W + 1)'(col);

  // Sweep addressing: scroll reads one row ahead except in the bottom row.
  assign sweep_live = (sweep_idx < SWEEP_W'(CELLS));
  assign sweep_src  = (sweep_idx[ADDR_W-1:0] < SCROLL_END)
                    ? sweep_idx[ADDR_W-1:0] + ADDR_W'(COLUMNS) : sweep_idx[ADDR_W-1:0];
  always_comb begin
    if (state == ST_CLEAR) begin
      sweep_data = '0;
    end else if (item_mode == MODE_FILL) begin
      sweep_data = {item_attr, item_char};
    end else if (wr_idx < SCROLL_END) begin
      sweep_data = ram_rd_data;
    end else begin
      sweep_data = ram_rd_data & CHAR_KEEP_MASK;
    end
  end

  // Command execution once the addressed cell has been read.
  always_comb begin
    cursor_next = cursor;
    col_next    = col;
    exec_we     = 1'b0;
    exec_data   = ram_rd_data;
    cell_out    = '0;
    unique case (item_mode)
      MODE_PRINT: begin
        if (item_char == CH_NEWLINE) begin
          if (nl_sum > (POS_W + 1)'(LAST_CELL)) begin
            cursor_next = LAST_CELL;
            col_next    = COL_LAST;
          end else begin
            cursor_next = nl_sum[POS_W-1:0];
            col_next    = '0;
          end
        end else if (item_char == CH_BACKSPACE) begin
          if (cursor == '0) begin
            cursor_next = LAST_CELL;
            col_next    = COL_LAST;
          end else begin
            cursor_next = cursor_dec;
            col_next    = (col == '0) ? COL_LAST : col - COL_W'(1);
            exec_we     = 1'b1;
            exec_data   = ram_rd_data & CHAR_KEEP_MASK;
          end
        end else begin
          exec_we   = 1'b1;
          exec_data = {ram_rd_data[CELL_W-1:BYTE_W], item_char};
          if (cursor != LAST_CELL) begin
            cursor_next = cursor + POS_W'(1);
            col_next    = (col == COL_LAST) ? '0 : col + COL_W'(1);
          end
        end
      end
      MODE_WRITE_CHAR: begin
        exec_we   = item_in_range;
        exec_data = {ram_rd_data[CELL_W-1:BYTE_W], item_char};
      end
      MODE_WRITE_ATTR: begin
        exec_we   = item_in_range;
        exec_data = {item_attr, ram_rd_data[BYTE_W-1:0]};
      end
      MODE_WRITE_CELL: begin
        exec_we   = item_in_range;
        exec_data = item_word;
      end
      MODE_READ: begin
        cell_out = item_in_range ? ram_rd_data : '0;
      end
      MODE_SET_FG: begin
        exec_we   = item_in_range;
        exec_data = (ram_rd_data & FG_KEEP_MASK) | {item_attr & NIBBLE_MASK, 8'h00};
      end
      MODE_CURSOR: begin
        cursor_next = item_pos;
        col_next    = rem_col;
      end
      default: begin
      end
    endcase
  end

  // Buffer port selection by state.
  always_comb begin
    ram_req = '0;
    unique case (state)
      ST_IDLE: begin
        ram_req.rd_en   = accept;
        ram_req.rd_addr = idle_addr;
      end
      ST_EXEC: begin
        ram_req.wr_en   = exec_we;
        ram_req.wr_addr = item_addr;
        ram_req.wr_data = exec_data;
      end
      ST_CLEAR, ST_SWEEP: begin
        ram_req.rd_en   = sweep_live;
        ram_req.rd_addr = sweep_src;
        ram_req.wr_en   = wr_pend;
        ram_req.wr_addr = wr_idx;
        ram_req.wr_data = sweep_data;
      end
      default: begin
      end
    endcase
  end

  // Result toward the output register.
  assign res_valid  = ((state == ST_EXEC) || (state == ST_DONE)) && out_free;
  assign res_cursor = (state == ST_EXEC) ? cursor_next : cursor;
  assign res_cell   = (state == ST_EXEC) ? cell_out : res_cell_r;

  // Sequencer state, cursor and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cursor    <= '0;
      col       <= '0;
      sweep_idx <= '0;
      wr_pend   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR, ST_SWEEP: begin
          if (sweep_live) begin
            wr_idx    <= sweep_idx[ADDR_W-1:0];
            wr_pend   <= 1'b1;
            sweep_idx <= sweep_idx + SWEEP_W'(1);
          end else begin
            wr_pend <= 1'b0;
            if (state == ST_CLEAR) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_DONE;
              if (item_mode == MODE_FILL) begin
                cursor <= '0;
                col    <= '0;
              end else if (cursor < POS_W'(COLUMNS)) begin
                cursor <= LAST_CELL;
                col    <= COL_LAST;
              end else begin
                cursor <= cursor - POS_W'(COLUMNS);
              end
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_mode     <= cmd_mode;
            item_char     <= cmd_char;
            item_attr     <= cmd_attr;
            item_word     <= cmd_word;
            item_in_range <= in_range_in;
            item_addr     <= idle_addr;
            item_pos      <= pos_clamped;
            quot          <= quot_prod[RECIP_SH +: ROW_W];
            res_cell_r    <= '0;
            if ((cmd_mode == MODE_FILL) || (cmd_mode == MODE_SCROLL)) begin
              state     <= ST_SWEEP;
              sweep_idx <= '0;
              wr_pend   <= 1'b0;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          cursor     <= cursor_next;
          col        <= col_next;
          res_cell_r <= cell_out;
          state      <= out_free ? ST_IDLE : ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT(a_cursor_in_screen, cursor <= LAST_CELL, "cursor left the screen")
  `TCW_ASSERT(a_col_in_row, col <= COL_LAST, "column tracker out of range")
  `TCW_ASSERT(a_no_write_on_accept, !(accept && ram_req.wr_en), "buffer write while accepting")
  `TCW_ASSERT_NEXT(a_single_result, res_valid, !res_valid, "result delivered twice")

endmodule
